// File: design/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int DEF_ROWS    = 25;
   localparam int DEF_COLUMNS = 76;

   localparam int KIND_W      = 2;
   localparam int CODE_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [CODE_W-1:0] CODE_NUL   = 8'd0;
   localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CODE_W-1:0] CODE_NL    = 8'd10;
   localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CODE_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]    read_data;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
   } rsp_type;

endpackage
`default_nettype wire

// File: design/tccw_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Character store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
   parameter int DEPTH = tccw_pkg::DEF_ROWS * tccw_pkg::DEF_COLUMNS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [tccw_pkg::CODE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [tccw_pkg::CODE_W-1:0] rd_data
);
   import tccw_pkg::*;

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/tccw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_seq
// Sequencer: cursor update, scroll copy, row fill, store clear and cell reads;
// cursor write and copy source share one adder, the sweeps share one counter.
// ----------------------------------------------------------------------------
module tccw_seq #(
   parameter int ROWS    = tccw_pkg::DEF_ROWS,
   parameter int COLUMNS = tccw_pkg::DEF_COLUMNS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tccw_pkg::req_type req_data,
   input  wire logic              rsp_free,
   output logic                   done,
   output tccw_pkg::rsp_type      result
);
   import tccw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] FILL_BASE = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_FILL  = 7'b0010000,
      ST_CLEAR = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   req_type           item_ff, item_in;
   logic              hit_ff, hit_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CODE_W-1:0] wr_data, rd_data;

   logic [AW-1:0]     row_base;
   logic [AW-1:0]     alu_a, alu_b, alu_sum;
   logic [RW:0]       row_next;
   logic [CW:0]       col_next;
   logic              in_range;

   // shared adder: cursor address during a write, source address during copy
   assign row_base = AW'(32'(row_ff) * COLUMNS);
   assign alu_a    = (state_ff == ST_COPY) ? cnt_ff : row_base;
   assign alu_b    = (state_ff == ST_COPY) ? COL_STEP : AW'(col_ff);
   assign alu_sum  = alu_a + alu_b;

   assign in_range = (32'(req_data.cell_index) < CELLS);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      item_in      = item_ff;
      hit_in       = hit_ff;
      req_ready    = 1'b0;
      done         = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = alu_sum;
      row_next     = {1'b0, row_ff};
      col_next     = {1'b0, col_ff};
      // drain the word read in the previous cycle by the scroll copy
      wr_en        = pend_ff;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            if (cnt_ff == CELL_LAST) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_data;
               hit_in  = in_range;
               case (req_data.kind)
                  KIND_WRITE: state_in = ST_WRITE;
                  KIND_READ: begin
                     rd_en    = in_range;
                     rd_addr  = AW'(req_data.cell_index);
                     state_in = ST_RESP;
                  end
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
            if (item_ff.char_code == CODE_NUL) begin
               // end-of-string marker: leave store and cursor alone
            end else if (item_ff.char_code == CODE_BS && col_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = alu_sum - 1'b1;
               wr_data = CODE_SPACE;
               col_in  = col_ff - 1'b1;
            end else begin
               if (item_ff.char_code == CODE_NL) begin
                  row_next = {1'b0, row_ff} + 1'b1;
                  col_next = '0;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = alu_sum;
                  wr_data  = item_ff.char_code;
                  col_next = {1'b0, col_ff} + 1'b1;
                  if (32'(col_next) == COLUMNS) begin
                     col_next = '0;
                     row_next = {1'b0, row_ff} + 1'b1;
                  end
               end
               if (32'(row_next) == ROWS) begin
                  row_in   = RW'(ROWS - 1);
                  col_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_COPY;
               end else begin
                  row_in = row_next[RW-1:0];
                  col_in = col_next[CW-1:0];
               end
            end
         end
         ST_COPY: begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = cnt_ff;
            if (cnt_ff == COPY_LAST) begin
               cnt_in   = FILL_BASE;
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FILL: begin
            // hold the counter while the last copied word drains
            if (!pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff;
               wr_data = '0;
               if (cnt_ff == CELL_LAST) begin
                  state_in = ST_RESP;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            done = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      result.read_data  = (item_ff.kind == KIND_READ && hit_ff) ? rd_data : '0;
      result.cursor_row = ROW_OUT_W'(row_ff);
      result.cursor_col = COL_OUT_W'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      item_ff      <= item_in;
      hit_ff       <= hit_in;
   end

   tccw_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

// File: design/text_console_char_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a character write passes IDLE, WRITE and RESP; a cell read or an unused
//   kind goes from IDLE straight to RESP. A write that scrolls runs a row copy,
//   then a last-row fill, before RESP; a clear sweeps the whole store. A held
//   result word stalls everything. Reset clears the store before any word is taken.
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console with cursor, backspace, newline, wrap and scroll, plus cell
// reads and full clear; result words sit in an output register.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int ROWS    = tccw_pkg::DEF_ROWS,
   parameter int COLUMNS = tccw_pkg::DEF_COLUMNS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tccw_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tccw_pkg::rsp_type      rsp_data
);
   import tccw_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_free;
   logic    done;
   rsp_type result;

   // output slot is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tccw_seq #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .done      (done),
      .result    (result)
   );

endmodule
`default_nettype wire

// File: dv/tb_text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking bench for the text console: a short table of directed words,
// then random lines of text, read-backs, clears and noise. Each result word is
// checked against its table entry or a cycle-free model of the store and cursor.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
   import tccw_pkg::*;

   localparam int ROWS  = DEF_ROWS;
   localparam int COLS  = DEF_COLUMNS;
   localparam int CELLS = ROWS * COLS;

   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type want;
   } console_step_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0]  screen [0:CELLS-1];
   int unsigned cur_r;
   int unsigned cur_c;

   rsp_type          pending_rsp [$];
   console_step_type directed_steps [$];
   int               real_items = 0;
   int               errors     = 0;
   logic             calm;

   assign calm = (real_items >= 900) && (real_items < 1200);

   text_console_char_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Apply one word to the console model and return the result word it gives.
   function automatic rsp_type console_step(input req_type w);
      rsp_type     r;
      int unsigned at;
      r = '0;
      case (w.kind)
         KIND_WRITE: begin
            if (w.char_code != CODE_NUL) begin
               at = cur_r * COLS + cur_c;
               if (w.char_code == CODE_BS && cur_c > 0) begin
                  screen[at - 1] = CODE_SPACE;
                  cur_c--;
               end else if (w.char_code == CODE_NL) begin
                  cur_r++;
                  cur_c = 0;
               end else begin
                  screen[at] = w.char_code;
                  cur_c++;
                  if (cur_c == COLS) begin
                     cur_c = 0;
                     cur_r++;
                  end
               end
               // scroll up one line, blank the last row
               if (cur_r == ROWS) begin
                  for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
                  for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = 8'd0;
                  cur_r = ROWS - 1;
                  cur_c = 0;
               end
            end
         end
         KIND_READ: begin
            if (w.cell_index < CELLS) r.read_data = screen[w.cell_index];
         end
         KIND_CLEAR: begin
            foreach (screen[i]) screen[i] = 8'd0;
         end
         default: ;
      endcase
      r.cursor_row = cur_r[ROW_OUT_W-1:0];
      r.cursor_col = cur_c[COL_OUT_W-1:0];
      return r;
   endfunction

   function automatic void add_step(input logic [KIND_W-1:0] kind,
                                    input logic [CODE_W-1:0] code,
                                    input int idx, input bit fixed,
                                    input int data, input int row, input int col);
      console_step_type s;
      s.word.kind       = kind;
      s.word.char_code  = code;
      s.word.cell_index = idx[INDEX_W-1:0];
      s.fixed           = fixed;
      s.want.read_data  = data[CODE_W-1:0];
      s.want.cursor_row = row[ROW_OUT_W-1:0];
      s.want.cursor_col = col[COL_OUT_W-1:0];
      directed_steps.push_back(s);
   endfunction

   // Offer one word, hold it until accepted, then log what it should return.
   task automatic send_word(input req_type w, input bit fixed, input rsp_type want);
      rsp_type predicted;
      if (!calm) begin
         while ($urandom_range(0, 99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = console_step(w);
      pending_rsp.push_back(fixed ? want : predicted);
      if (w.kind == KIND_READ || w.kind == KIND_CLEAR ||
          (w.kind == KIND_WRITE && w.char_code != CODE_NUL)) real_items++;
   endtask

   initial begin : stimulus
      req_type     w;
      int          pick;
      int          roll;
      int          len;
      int          reads;
      int unsigned rd_row;

      foreach (screen[i]) screen[i] = 8'd0;
      cur_r = 0;
      cur_c = 0;

      //        kind        code        idx   fixed data row col
      add_step(KIND_READ,  CODE_NUL,   0,    1,    0,   0,  0);
      add_step(KIND_READ,  CODE_NUL,   2047, 1,    0,   0,  0);
      add_step(KIND_READ,  CODE_NUL,   1899, 1,    0,   0,  0);
      add_step(KIND_READ,  8'hFF,      1900, 1,    0,   0,  0);
      add_step(KIND_WRITE, CODE_NUL,   0,    1,    0,   0,  0);
      add_step(KIND_WRITE, CODE_BS,    0,    1,    0,   0,  1);
      add_step(KIND_READ,  CODE_NUL,   0,    1,    8,   0,  1);
      add_step(KIND_WRITE, 8'hFF,      2047, 1,    0,   0,  2);
      add_step(KIND_READ,  CODE_NUL,   1,    1,    255, 0,  2);
      add_step(KIND_WRITE, CODE_BS,    0,    1,    0,   0,  1);
      add_step(KIND_READ,  CODE_NUL,   1,    1,    32,  0,  1);
      add_step(KIND_WRITE, CODE_NL,    0,    1,    0,   1,  0);
      add_step(2'd3,       8'hFF,      2047, 1,    0,   1,  0);
      add_step(KIND_WRITE, 8'd1,       0,    0,    0,   0,  0);
      add_step(KIND_WRITE, 8'd65,      1234, 0,    0,   0,  0);
      add_step(KIND_READ,  CODE_NUL,   76,   0,    0,   0,  0);
      add_step(KIND_CLEAR, 8'hFF,      2047, 1,    0,   1,  2);
      add_step(KIND_READ,  CODE_NUL,   76,   1,    0,   1,  2);
      add_step(KIND_WRITE, CODE_BS,    0,    0,    0,   0,  0);
      add_step(KIND_WRITE, CODE_NL,    0,    0,    0,   0,  0);
      add_step(KIND_READ,  CODE_NUL,   0,    0,    0,   0,  0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_word(directed_steps[i].word, directed_steps[i].fixed, directed_steps[i].want);

      while (real_items < 2000) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // one line of text, then read back cells, mostly near the cursor
            len = $urandom_range(1, 80);
            for (int k = 0; k < len; k++) begin
               w.kind       = KIND_WRITE;
               w.cell_index = INDEX_W'($urandom_range(0, 2047));
               roll         = $urandom_range(0, 99);
               if (roll < 8)       w.char_code = CODE_BS;
               else if (roll < 20) w.char_code = CODE_W'($urandom_range(0, 255));
               else                w.char_code = CODE_W'($urandom_range(33, 126));
               send_word(w, 1'b0, '0);
            end
            if ($urandom_range(0, 99) < 70) begin
               w.kind       = KIND_WRITE;
               w.char_code  = CODE_NL;
               w.cell_index = INDEX_W'($urandom_range(0, 2047));
               send_word(w, 1'b0, '0);
            end
            reads = $urandom_range(1, 4);
            for (int k = 0; k < reads; k++) begin
               w.kind      = KIND_READ;
               w.char_code = CODE_W'($urandom_range(0, 255));
               if ($urandom_range(0, 99) < 20) begin
                  w.cell_index = INDEX_W'($urandom_range(0, 2047));
               end else begin
                  rd_row = (cur_r > 0 && $urandom_range(0, 1)) ? cur_r - 1 : cur_r;
                  w.cell_index = INDEX_W'(rd_row * COLS + $urandom_range(0, COLS - 1));
               end
               send_word(w, 1'b0, '0);
            end
         end else if (pick < 69) begin
            w.kind       = KIND_CLEAR;
            w.char_code  = CODE_W'($urandom_range(0, 255));
            w.cell_index = INDEX_W'($urandom_range(0, 2047));
            send_word(w, 1'b0, '0);
         end else begin
            w.kind       = KIND_W'($urandom_range(0, 3));
            w.char_code  = CODE_W'($urandom_range(0, 255));
            w.cell_index = INDEX_W'($urandom_range(0, 2047));
            send_word(w, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("tb_text_console_char_writer: done, clean");
      else
         $display("tb_text_console_char_writer: done, errors");
      $finish;
   end

   initial begin : sink
      int      hold_left;
      bit      hold_done;
      rsp_type want;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected word, expected none got %h", $time, rsp_data);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.read_data != want.read_data) begin
                  $display("%0t: read_data expected %0d got %0d",
                           $time, want.read_data, rsp_data.read_data);
                  errors++;
               end
               if (rsp_data.cursor_row != want.cursor_row) begin
                  $display("%0t: cursor_row expected %0d got %0d",
                           $time, want.cursor_row, rsp_data.cursor_row);
                  errors++;
               end
               if (rsp_data.cursor_col != want.cursor_col) begin
                  $display("%0t: cursor_col expected %0d got %0d",
                           $time, want.cursor_col, rsp_data.cursor_col);
                  errors++;
               end
            end
         end
         // hold off once for a long stretch so the block backs up its input
         if (!hold_done && real_items >= 300) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 30);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("tb_text_console_char_writer: done, errors");
      $finish;
   end

endmodule
